// ===== sv/kpes_pkg.sv =====
// Shared types, constants and helpers for the keypad matrix event scanner.
// No dependencies; imported by kpes_event_queue and the top level.
`default_nettype none

package kpes_pkg;

    localparam int MAX_ROWS     = 8;
    localparam int MAX_COLUMNS  = 8;
    localparam int EVENT_DEPTH  = 64;

    localparam int SLOT_COUNT   = MAX_ROWS * MAX_COLUMNS;
    localparam int SLOT_W       = $clog2(SLOT_COUNT);
    localparam int SLOT_CNT_W   = $clog2(SLOT_COUNT + 1);
    localparam int COL_W        = 3;
    localparam int ROW_W        = 3;
    localparam int CODE_W       = 8;
    localparam int FLAG_W       = 3;
    localparam int CFG_W        = 4;
    localparam int CFG_IDX_W    = 1;
    localparam int EV_PTR_W     = $clog2(EVENT_DEPTH);
    localparam int EV_CNT_W     = $clog2(EVENT_DEPTH + 1);
    localparam int WAITING_W    = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] ROWS_RESET    = CFG_W'(MAX_ROWS);
    localparam logic [CFG_W-1:0] COLUMNS_RESET = CFG_W'(MAX_COLUMNS);

    // per-key flag bits
    localparam logic [FLAG_W-1:0] FLAG_DOWN      = 3'b001;
    localparam logic [FLAG_W-1:0] FLAG_JUST_DOWN = 3'b010;
    localparam logic [FLAG_W-1:0] FLAG_JUST_UP   = 3'b100;

    typedef enum logic [2:0] {
        REQ_SCAN        = 3'd0,
        REQ_JUST_DOWN   = 3'd1,
        REQ_JUST_UP     = 3'd2,
        REQ_IS_DOWN     = 3'd3,
        REQ_IS_UP       = 3'd4,
        REQ_POP         = 3'd5,
        REQ_CLEAR       = 3'd6,
        REQ_LOAD        = 3'd7
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_DROPPED   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_POP,
        S_RESP
    } state_t;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic              clear;
        logic              kind;
        logic [CODE_W-1:0] code;
    } ev_ctl_t;

    typedef struct packed {
        logic [EV_CNT_W-1:0] count;
        logic                full;
        logic                empty;
    } ev_stat_t;

    // zero acts as one, anything above the maximum as the maximum
    function automatic logic [CFG_W-1:0] clamp_count(input logic [CFG_W-1:0] v,
                                                     input logic [CFG_W-1:0] max_v);
        logic [CFG_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (v > max_v) begin
            r = max_v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/kpes_event_queue.sv =====
// Event FIFO of the keypad scanner: one synchronous memory plus head, tail and count.
// Depends on kpes_pkg; pop data appears in the cycle after the pop request.
`default_nettype none

module kpes_event_queue
    import kpes_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ev_ctl_t           ctl,
    output ev_stat_t               stat,
    output logic                   rd_kind,
    output logic [CODE_W-1:0]      rd_code
);

    logic [CODE_W:0]       event_mem [EVENT_DEPTH];
    logic [CODE_W:0]       rd_data_reg;
    logic [EV_PTR_W-1:0]   head_reg, head_next;
    logic [EV_PTR_W-1:0]   tail_reg, tail_next;
    logic [EV_CNT_W-1:0]   count_reg, count_next;

    function automatic logic [EV_PTR_W-1:0] ptr_inc(input logic [EV_PTR_W-1:0] p);
        logic [EV_PTR_W-1:0] r;
        r = (p == EV_PTR_W'(EVENT_DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctl.clear) begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end else if (ctl.push) begin
            tail_next  = ptr_inc(tail_reg);
            count_next = count_reg + 1'b1;
        end else if (ctl.pop) begin
            head_next  = ptr_inc(head_reg);
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.push && !ctl.clear) begin
            event_mem[tail_reg] <= {ctl.kind, ctl.code};
        end
        if (ctl.pop) begin
            rd_data_reg <= event_mem[head_reg];
        end
    end

    assign stat.count = count_reg;
    assign stat.full  = (count_reg == EV_CNT_W'(EVENT_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign rd_kind    = rd_data_reg[CODE_W];
    assign rd_code    = rd_data_reg[CODE_W-1:0];

endmodule

`default_nettype wire

// ===== sv/keypad_matrix_event_scanner_top.sv =====
// Keypad matrix event scanner: key flags and key codes in synchronous memories, event FIFO.
// A scan of an unused row skips the walk; a query stops at the first slot whose code matches.
// A query walks the code memory one slot a cycle; a scan walks one column a cycle.
// Throughput: one request at a time, the next taken the cycle after the result is loaded.
// Reset: flags read as zero, queue empty, rows and columns in use set to 8; codes undefined.
`default_nettype none

module keypad_matrix_event_scanner_top
    import kpes_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_wdata,
    // request channel
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [2:0]            s_req_type,
    input  wire logic [ROW_W-1:0]      s_row_index,
    input  wire logic [MAX_COLUMNS-1:0] s_column_bits,
    input  wire logic [CODE_W-1:0]     s_key_code,
    input  wire logic                  s_clear_after,
    input  wire logic [5:0]            s_key_slot,
    // result channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [1:0]                 m_status,
    output logic                       m_flag_answer,
    output logic                       m_event_kind,
    output logic [CODE_W-1:0]          m_event_key,
    output logic [WAITING_W-1:0]       m_events_waiting
);

    localparam int ADDR_FULL_W = SLOT_CNT_W + 1;

    state_t                 state_reg, state_next;
    logic [CFG_W-1:0]       rows_reg, cols_reg;

    req_type_t              req_reg, req_next;
    logic [ROW_W-1:0]       row_reg, row_next;
    logic [MAX_COLUMNS-1:0] bits_reg, bits_next;
    logic [CODE_W-1:0]      code_reg, code_next;
    logic                   clr_reg, clr_next;
    logic [5:0]             slot_reg, slot_next;

    logic [SLOT_CNT_W-1:0]  idx_reg, idx_next;
    logic                   pend_reg, pend_next;
    logic [SLOT_W-1:0]      paddr_reg, paddr_next;
    logic [COL_W-1:0]       pcol_reg, pcol_next;
    logic [SLOT_COUNT-1:0]  valid_reg, valid_next;

    status_t                status_reg, status_next;
    logic                   answer_reg, answer_next;
    logic                   kind_reg, kind_next;
    logic [CODE_W-1:0]      ekey_reg, ekey_next;

    logic                   m_valid_reg, m_valid_next;
    logic [1:0]             m_status_reg, m_status_next;
    logic                   m_answer_reg, m_answer_next;
    logic                   m_kind_reg, m_kind_next;
    logic [CODE_W-1:0]      m_key_reg, m_key_next;
    logic [WAITING_W-1:0]   m_waiting_reg, m_waiting_next;

    // key state memories
    logic [FLAG_W-1:0]      flag_mem [SLOT_COUNT];
    logic [CODE_W-1:0]      code_mem [SLOT_COUNT];
    logic [FLAG_W-1:0]      flags_q;
    logic [CODE_W-1:0]      codes_q;
    logic                   mem_rd_en;
    logic [SLOT_W-1:0]      mem_rd_addr;
    logic                   flag_we;
    logic [FLAG_W-1:0]      flag_wdata;
    logic                   code_we;
    logic [SLOT_W-1:0]      code_waddr;

    ev_ctl_t                ev_ctl;
    ev_stat_t               ev_stat;
    logic                   ev_rd_kind;
    logic [CODE_W-1:0]      ev_rd_code;

    logic [CFG_W-1:0]       rows_eff, cols_eff;
    logic [SLOT_CNT_W-1:0]  slots_in_use, walk_limit;
    logic [ADDR_FULL_W-1:0] scan_addr;
    logic                   is_scan, row_in_use, walk_more, walk_done, code_hit, out_free;
    logic [FLAG_W-1:0]      cur_flags;

    kpes_event_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ev_ctl),
        .stat    (ev_stat),
        .rd_kind (ev_rd_kind),
        .rd_code (ev_rd_code)
    );

    assign rows_eff     = clamp_count(rows_reg, CFG_W'(MAX_ROWS));
    assign cols_eff     = clamp_count(cols_reg, CFG_W'(MAX_COLUMNS));
    assign slots_in_use = SLOT_CNT_W'(rows_eff) * SLOT_CNT_W'(cols_eff);
    assign is_scan      = (req_reg == REQ_SCAN);
    assign row_in_use   = ({1'b0, row_reg} < rows_eff);
    assign walk_limit   = is_scan ? SLOT_CNT_W'(cols_eff) : slots_in_use;
    assign scan_addr    = ADDR_FULL_W'(row_reg) * ADDR_FULL_W'(cols_eff)
                        + ADDR_FULL_W'(idx_reg);
    assign walk_more    = (idx_reg < walk_limit);
    assign walk_done    = !walk_more && !pend_reg;
    assign cur_flags    = valid_reg[paddr_reg] ? flags_q : '0;
    assign code_hit     = pend_reg && !is_scan && (codes_q == code_reg);
    assign out_free     = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                case (req_reg)
                    REQ_SCAN:      state_next = row_in_use ? S_WALK : S_RESP;
                    REQ_JUST_DOWN: state_next = S_WALK;
                    REQ_JUST_UP:   state_next = S_WALK;
                    REQ_IS_DOWN:   state_next = S_WALK;
                    REQ_IS_UP:     state_next = S_WALK;
                    REQ_POP:       state_next = ev_stat.empty ? S_RESP : S_POP;
                    default:       state_next = S_RESP;
                endcase
            end
            S_WALK: begin
                if (code_hit || walk_done) begin
                    state_next = S_RESP;
                end
            end
            S_POP: begin
                state_next = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        req_next       = req_reg;
        row_next       = row_reg;
        bits_next      = bits_reg;
        code_next      = code_reg;
        clr_next       = clr_reg;
        slot_next      = slot_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        paddr_next     = paddr_reg;
        pcol_next      = pcol_reg;
        valid_next     = valid_reg;
        status_next    = status_reg;
        answer_next    = answer_reg;
        kind_next      = kind_reg;
        ekey_next      = ekey_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_status_next  = m_status_reg;
        m_answer_next  = m_answer_reg;
        m_kind_next    = m_kind_reg;
        m_key_next     = m_key_reg;
        m_waiting_next = m_waiting_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = idx_reg[SLOT_W-1:0];
        flag_we        = 1'b0;
        flag_wdata     = cur_flags;
        code_we        = 1'b0;
        code_waddr     = SLOT_W'(slot_reg);
        ev_ctl         = '0;
        s_ready        = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next  = req_type_t'(s_req_type);
                    row_next  = s_row_index;
                    bits_next = s_column_bits;
                    code_next = s_key_code;
                    clr_next  = s_clear_after;
                    slot_next = s_key_slot;
                end
            end
            S_EXEC: begin
                status_next = ST_OK;
                answer_next = 1'b0;
                kind_next   = 1'b0;
                ekey_next   = '0;
                idx_next    = '0;
                case (req_reg)
                    REQ_POP: begin
                        if (ev_stat.empty) begin
                            status_next = ST_EMPTY;
                        end else begin
                            ev_ctl.pop = 1'b1;
                        end
                    end
                    REQ_CLEAR: begin
                        ev_ctl.clear = 1'b1;
                        valid_next   = '0;
                    end
                    REQ_LOAD: begin
                        code_we = (int'(slot_reg) < SLOT_COUNT);
                    end
                    default: begin
                    end
                endcase
            end
            S_WALK: begin
                // read one slot a cycle, handle the previous one's data
                if (walk_more && !code_hit) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = is_scan ? scan_addr[SLOT_W-1:0] : idx_reg[SLOT_W-1:0];
                    idx_next    = idx_reg + 1'b1;
                    pend_next   = 1'b1;
                    paddr_next  = mem_rd_addr;
                    pcol_next   = idx_reg[COL_W-1:0];
                end
                if (pend_reg && is_scan) begin
                    if (bits_reg[pcol_reg] && !cur_flags[0]) begin
                        flag_we     = 1'b1;
                        flag_wdata  = cur_flags | FLAG_DOWN | FLAG_JUST_DOWN;
                        ev_ctl.kind = 1'b1;
                        ev_ctl.code = codes_q;
                        ev_ctl.push = !ev_stat.full;
                        if (ev_stat.full) begin
                            status_next = ST_DROPPED;
                        end
                    end else if (!bits_reg[pcol_reg] && cur_flags[0]) begin
                        flag_we     = 1'b1;
                        flag_wdata  = (cur_flags | FLAG_JUST_UP) & ~FLAG_DOWN;
                        ev_ctl.kind = 1'b0;
                        ev_ctl.code = codes_q;
                        ev_ctl.push = !ev_stat.full;
                        if (ev_stat.full) begin
                            status_next = ST_DROPPED;
                        end
                    end
                end
                if (code_hit) begin
                    case (req_reg)
                        REQ_JUST_DOWN: begin
                            answer_next = |(cur_flags & FLAG_JUST_DOWN);
                            flag_we     = clr_reg;
                            flag_wdata  = cur_flags & ~FLAG_JUST_DOWN;
                        end
                        REQ_JUST_UP: begin
                            answer_next = |(cur_flags & FLAG_JUST_UP);
                            flag_we     = 1'b1;
                            flag_wdata  = cur_flags & ~FLAG_JUST_UP;
                        end
                        REQ_IS_DOWN: answer_next = |(cur_flags & FLAG_DOWN);
                        default:     answer_next = ~|(cur_flags & FLAG_DOWN);
                    endcase
                end
                if (walk_done && !is_scan) begin
                    status_next = ST_NOT_FOUND;
                end
                if (flag_we) begin
                    valid_next[paddr_reg] = 1'b1;
                end
            end
            S_POP: begin
                kind_next = ev_rd_kind;
                ekey_next = ev_rd_code;
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_status_next  = status_reg;
                    m_answer_next  = answer_reg;
                    m_kind_next    = kind_reg;
                    m_key_next     = ekey_reg;
                    m_waiting_next = WAITING_W'(ev_stat.count);
                end
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            rows_reg    <= ROWS_RESET;
            cols_reg    <= COLUMNS_RESET;
            pend_reg    <= 1'b0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_ROWS:    rows_reg <= cfg_wdata;
                    CFG_COLUMNS: cols_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        row_reg       <= row_next;
        bits_reg      <= bits_next;
        code_reg      <= code_next;
        clr_reg       <= clr_next;
        slot_reg      <= slot_next;
        idx_reg       <= idx_next;
        paddr_reg     <= paddr_next;
        pcol_reg      <= pcol_next;
        status_reg    <= status_next;
        answer_reg    <= answer_next;
        kind_reg      <= kind_next;
        ekey_reg      <= ekey_next;
        m_status_reg  <= m_status_next;
        m_answer_reg  <= m_answer_next;
        m_kind_reg    <= m_kind_next;
        m_key_reg     <= m_key_next;
        m_waiting_reg <= m_waiting_next;
    end

    // flag and code memories, registered read
    always_ff @(posedge aclk) begin
        if (flag_we) begin
            flag_mem[paddr_reg] <= flag_wdata;
        end
        if (mem_rd_en) begin
            flags_q <= flag_mem[mem_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (code_we) begin
            code_mem[code_waddr] <= code_reg;
        end
        if (mem_rd_en) begin
            codes_q <= code_mem[mem_rd_addr];
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_flag_answer    = m_answer_reg;
    assign m_event_kind     = m_kind_reg;
    assign m_event_key      = m_key_reg;
    assign m_events_waiting = m_waiting_reg;

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ev_ctl.push |-> !ev_stat.full)
        else $error("event pushed into a full queue");

    a_no_push_and_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ev_ctl.push && ev_ctl.pop))
        else $error("push and pop in the same cycle");

    a_pend_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (state_reg == S_WALK))
        else $error("pending memory read outside the slot walk");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC && req_reg == REQ_CLEAR) |=>
            (valid_reg == '0 && ev_stat.count == '0))
        else $error("clear left flags or events behind");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ev_stat.count <= EV_CNT_W'(EVENT_DEPTH))
        else $error("event count above queue depth");

endmodule

`default_nettype wire
